[hw/rtl/lcc_pkg.sv]
// ---------------------------------------------------------------------------
// lcc_pkg
// Shared widths, reset values and register indexes of the clock catch-up
// driver.
// ---------------------------------------------------------------------------
package lcc_pkg;

  localparam int unsigned DayW    = 16;
  localparam int unsigned SodW    = 17;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned WidthW  = 8;
  localparam int unsigned GapW    = 16;
  localparam int unsigned PeriodW = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // Wide enough for seconds of day plus one full day
  localparam int unsigned SumW    = 18;

  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned MinsPerHour = 60;
  localparam int unsigned HoursPerDay = 24;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerDay  = 86400;

  localparam logic [WidthW-1:0]  ResetPulseWidth  = WidthW'(35);
  localparam logic [GapW-1:0]    ResetMinGap      = GapW'(400);
  localparam logic [PeriodW-1:0] ResetCheckPeriod = PeriodW'(100);

  localparam logic [CfgIdxW-1:0] CFG_PULSE_WIDTH  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_MIN_GAP      = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_CHECK_PERIOD = CfgIdxW'(2);

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;

endpackage

[hw/rtl/lcc_if.sv]
// ---------------------------------------------------------------------------
// lcc_if
// Valid/ready channels of the clock catch-up driver: tick/set items in,
// coil and hand results out, register writes.
// ---------------------------------------------------------------------------
interface lcc_in_if;
  import lcc_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [DayW-1:0]    cur_day;
  logic [SodW-1:0]    cur_second_of_day;
  logic [HourW-1:0]   set_hour;
  logic [MinW-1:0]    set_minute;
  logic [SecW-1:0]    set_second;

  modport source (output valid, mode, cur_day, cur_second_of_day, set_hour,
                  set_minute, set_second, input ready);
  modport sink (input valid, mode, cur_day, cur_second_of_day, set_hour,
                set_minute, set_second, output ready);
endinterface

interface lcc_out_if;
  import lcc_pkg::*;
  logic               valid;
  logic               ready;
  logic               coil_a;
  logic               coil_b;
  logic [HourW-1:0]   hand_hour;
  logic [MinW-1:0]    hand_minute;
  logic [SecW-1:0]    hand_second;
  logic               stepped;

  modport source (output valid, coil_a, coil_b, hand_hour, hand_minute,
                  hand_second, stepped, input ready);
  modport sink (input valid, coil_a, coil_b, hand_hour, hand_minute,
                hand_second, stepped, output ready);
endinterface

interface lcc_cfg_if;
  import lcc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/lavet_clock_catchup_driver_unit.sv]
// ---------------------------------------------------------------------------
// lavet_clock_catchup_driver_unit
// Tracks Lavet stepper hand positions, checks them against true time and
// drives one coil pulse per step while the hands lag.
// ---------------------------------------------------------------------------
// Path: the input register loads on the accepting edge, then the state and
//   result register load from it; both hold while the output is stalled.
// Throughput: 1 item per cycle unless dst stalls; one short hand/counter pass.
// Reset: hands, day and counters clear, pulse age saturates, registers take
//   their default values; no clearing pass.
module lavet_clock_catchup_driver_unit (
  input logic       clk,
  input logic       rst,
  lcc_in_if.sink    src,
  lcc_out_if.source dst,
  lcc_cfg_if.sink   cfg
);
  import lcc_pkg::*;

  // Configuration registers
  logic [WidthW-1:0]  pulse_width_ms;
  logic [GapW-1:0]    min_gap_ms;
  logic [PeriodW-1:0] check_period_ms;

  // Input register
  logic               s1_valid;
  logic               s1_mode;
  logic [DayW-1:0]    s1_day;
  logic [SodW-1:0]    s1_sod;
  logic [HourW-1:0]   s1_hour;
  logic [MinW-1:0]    s1_minute;
  logic [SecW-1:0]    s1_second;

  // Block state
  logic [HourW-1:0]   hour_pos, hour_pos_next;
  logic [MinW-1:0]    minute_pos, minute_pos_next;
  logic [SecW-1:0]    second_pos, second_pos_next;
  logic [DayW-1:0]    hands_day, hands_day_next;
  logic [GapW-1:0]    since_pulse, since_pulse_next;
  logic [PeriodW-1:0] check_phase, check_phase_next;
  logic [WidthW-1:0]  pulse_left, pulse_left_next;
  logic               pulse_positive, pulse_positive_next;

  // Result register
  logic               out_valid;
  logic               out_coil_a;
  logic               out_coil_b;
  logic [HourW-1:0]   out_hour;
  logic [MinW-1:0]    out_minute;
  logic [SecW-1:0]    out_second;
  logic               out_stepped;

  logic               advance;
  logic               step;
  logic               check;
  logic               lag;
  logic [DayW:0]      day_diff;
  logic [SumW-1:0]    hands_sod;
  logic [SumW-1:0]    true_sod;
  logic [PeriodW:0]   phase_inc;
  logic [GapW-1:0]    since_inc;
  logic [WidthW-1:0]  left_dec;

  assign advance   = !out_valid || dst.ready;
  assign src.ready = !s1_valid || advance;
  assign cfg.ready = 1'b1;

  // Lag compare split by day difference: beyond one day apart the answer
  // follows from the sign, since neither seconds-of-day term reaches 2 days.
  assign day_diff  = {1'b0, s1_day} - {1'b0, hands_day};
  assign hands_sod = SumW'(hour_pos) * SumW'(SecsPerHour)
                   + SumW'(minute_pos) * SumW'(SecsPerMin)
                   + SumW'(second_pos);
  assign true_sod  = SumW'(s1_sod);

  always_comb begin
    if (day_diff == '0) begin
      lag = true_sod > hands_sod;
    end else if (day_diff == (DayW+1)'(1)) begin
      lag = (true_sod + SumW'(SecsPerDay)) > hands_sod;
    end else if (day_diff == '1) begin
      lag = true_sod > (hands_sod + SumW'(SecsPerDay));
    end else begin
      lag = !day_diff[DayW];
    end
  end

  assign phase_inc = {1'b0, check_phase} + (PeriodW+1)'(1);
  assign since_inc = (since_pulse == '1) ? since_pulse : since_pulse + GapW'(1);
  assign left_dec  = (pulse_left == '0) ? pulse_left : pulse_left - WidthW'(1);
  assign check     = phase_inc >= {1'b0, check_period_ms};
  assign step      = (s1_mode == MODE_TICK) && check && lag && (since_inc > min_gap_ms);

  always_comb begin
    hour_pos_next       = hour_pos;
    minute_pos_next     = minute_pos;
    second_pos_next     = second_pos;
    hands_day_next      = hands_day;
    since_pulse_next    = since_pulse;
    check_phase_next    = check_phase;
    pulse_left_next     = pulse_left;
    pulse_positive_next = pulse_positive;
    if (s1_mode == MODE_SET) begin
      hour_pos_next   = s1_hour;
      minute_pos_next = s1_minute;
      second_pos_next = s1_second;
      hands_day_next  = s1_day;
    end else begin
      since_pulse_next = since_inc;
      pulse_left_next  = left_dec;
      check_phase_next = check ? '0 : phase_inc[PeriodW-1:0];
      if (step) begin
        pulse_positive_next = !second_pos[0];
        pulse_left_next     = pulse_width_ms;
        since_pulse_next    = '0;
        // Advance one second with carries; hands at or past the top wrap
        if (32'(second_pos) + 32'd1 < SecsPerMin) begin
          second_pos_next = second_pos + SecW'(1);
        end else begin
          second_pos_next = '0;
          if (32'(minute_pos) + 32'd1 < MinsPerHour) begin
            minute_pos_next = minute_pos + MinW'(1);
          end else begin
            minute_pos_next = '0;
            if (32'(hour_pos) + 32'd1 < HoursPerDay) begin
              hour_pos_next = hour_pos + HourW'(1);
            end else begin
              hour_pos_next  = '0;
              hands_day_next = s1_day;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_width_ms  <= ResetPulseWidth;
      min_gap_ms      <= ResetMinGap;
      check_period_ms <= ResetCheckPeriod;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PULSE_WIDTH:  pulse_width_ms  <= cfg.data[WidthW-1:0];
        CFG_MIN_GAP:      min_gap_ms      <= cfg.data[GapW-1:0];
        CFG_CHECK_PERIOD: check_period_ms <= cfg.data[PeriodW-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src.ready) begin
      s1_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.ready && src.valid) begin
      s1_mode   <= src.mode;
      s1_day    <= src.cur_day;
      s1_sod    <= src.cur_second_of_day;
      s1_hour   <= src.set_hour;
      s1_minute <= src.set_minute;
      s1_second <= src.set_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_pos       <= '0;
      minute_pos     <= '0;
      second_pos     <= '0;
      hands_day      <= '0;
      since_pulse    <= '1;
      check_phase    <= '0;
      pulse_left     <= '0;
      pulse_positive <= 1'b0;
      out_valid      <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        hour_pos       <= hour_pos_next;
        minute_pos     <= minute_pos_next;
        second_pos     <= second_pos_next;
        hands_day      <= hands_day_next;
        since_pulse    <= since_pulse_next;
        check_phase    <= check_phase_next;
        pulse_left     <= pulse_left_next;
        pulse_positive <= pulse_positive_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_coil_a  <= (pulse_left_next != '0) && pulse_positive_next;
      out_coil_b  <= (pulse_left_next != '0) && !pulse_positive_next;
      out_hour    <= hour_pos_next;
      out_minute  <= minute_pos_next;
      out_second  <= second_pos_next;
      out_stepped <= step;
    end
  end

  assign dst.valid       = out_valid;
  assign dst.coil_a      = out_coil_a;
  assign dst.coil_b      = out_coil_b;
  assign dst.hand_hour   = out_hour;
  assign dst.hand_minute = out_minute;
  assign dst.hand_second = out_second;
  assign dst.stepped     = out_stepped;

  a_coils_exclusive: assert property (@(posedge clk) disable iff (rst)
    dst.valid |-> !(dst.coil_a && dst.coil_b))
    else $error("both coils driven");

  a_step_clears_age: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && step) |=> (since_pulse == '0 && dst.valid && dst.stepped))
    else $error("step did not restart pulse age");

  a_coil_needs_pulse: assert property (@(posedge clk) disable iff (rst)
    (dst.valid && (dst.coil_a || dst.coil_b)) |-> (pulse_left != '0))
    else $error("coil driven with no pulse left");

  a_set_no_step: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && s1_mode == MODE_SET) |=> !dst.stepped)
    else $error("set item reported a step");

endmodule
